### rtl/core/bsrc_pkg.sv
// shared types and codes of the banker's safety request checker
`timescale 1ns / 1ps

package bsrc_pkg;

  // field widths fixed by the request and result formats
  localparam int DATA_W    = 8;
  localparam int WORK_W    = 12;
  localparam int NEED_W    = 13;
  localparam int PIDX_W    = 3;
  localparam int RIDX_W    = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [WORK_W-1:0] WORK_MAX = 12'hFFF;

  // process and resource counts after reset
  localparam int PROC_COUNT_RST = 8;
  localparam int RES_COUNT_RST  = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_COUNT  = 1'b1;

  // request operations
  typedef logic [1:0] op_t;
  localparam op_t OP_WR_ALLOC = 2'd0;
  localparam op_t OP_WR_CLAIM = 2'd1;
  localparam op_t OP_WR_AVAIL = 2'd2;
  localparam op_t OP_REQ_ELEM = 2'd3;

  // result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_WRITTEN = 3'd0;
  localparam status_t ST_STORED  = 3'd1;
  localparam status_t ST_EXCEEDS = 3'd2;
  localparam status_t ST_UNAVAIL = 3'd3;
  localparam status_t ST_SAFE    = 3'd4;
  localparam status_t ST_UNSAFE  = 3'd5;

  typedef struct packed {
    op_t               operation;
    logic [PIDX_W-1:0] process_index;
    logic [RIDX_W-1:0] resource_index;
    logic [DATA_W-1:0] value;
    logic              is_last;
  } req_item_t;

  typedef struct packed {
    status_t           status;
    logic [PIDX_W-1:0] sequence_process;
    logic              last_result;
  } req_result_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    take;
    logic    rd_row;
    logic    grant;
    logic    rollback;
    logic    commit;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
    logic    emit_seq;
    logic    clr_pending;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic over_need;
    logic over_avail;
    logic fits;
    logic proc_done;
  } dp_stat_t;

endpackage

### rtl/core/bankers_safety_request_checker.sv
// top level of the banker's safety request checker
`timescale 1ns / 1ps

// Deadlock-avoidance request checker. A request is taken when start is high
// and busy is low. For table writes, pool writes and non-final request
// elements the result is strobed on out_valid the next cycle and busy stays
// low, so such requests can follow back to back. A final request element
// raises busy: S_REQ_RD and S_REQ_CHK do the need and pool checks, then the
// safety check reads one process row of the single-port tables per step, in
// S_SC_RD and S_SC_CHK for an unfinished process, S_SC_RD alone for a finished
// one, over at most np passes of np processes (np = process count); a safe
// grant then strobes np sequence results on consecutive cycles, a refusal or
// rollback one result. Each result is valid for exactly one cycle and cannot
// be held off. Configuration writes take effect at once and belong in idle time.
module bankers_safety_request_checker
  import bsrc_pkg::*;
#(
  parameter int MAX_PROCESSES = 8,
  parameter int MAX_RESOURCES = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  req_item_t            in_item,
  output logic                 out_valid,
  output req_result_t          out_result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int PW  = $clog2(MAX_PROCESSES);
  localparam int PCW = $clog2(MAX_PROCESSES + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);
  localparam int NP_RST = (MAX_PROCESSES < PROC_COUNT_RST) ? MAX_PROCESSES : PROC_COUNT_RST;
  localparam int NR_RST = (MAX_RESOURCES < RES_COUNT_RST) ? MAX_RESOURCES : RES_COUNT_RST;

  logic [PCW-1:0] np_r, np_nxt;
  logic [RCW-1:0] nr_r, nr_nxt;
  ctrl_cmd_t      cmd;
  dp_stat_t       stat;
  logic [PW-1:0]  idx;

  // counts are held already clamped to the range in use
  always_comb begin
    if (cfg_data == '0) begin
      np_nxt = PCW'(1);
    end else if (int'(cfg_data) > MAX_PROCESSES) begin
      np_nxt = PCW'(MAX_PROCESSES);
    end else begin
      np_nxt = PCW'(cfg_data);
    end
    if (cfg_data[2:0] == '0) begin
      nr_nxt = RCW'(1);
    end else if (int'(cfg_data[2:0]) > MAX_RESOURCES) begin
      nr_nxt = RCW'(MAX_RESOURCES);
    end else begin
      nr_nxt = RCW'(cfg_data[2:0]);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r <= PCW'(NP_RST);
      nr_r <= RCW'(NR_RST);
    end else if (cfg_we) begin
      if (cfg_index == CFG_PROC_COUNT) np_r <= np_nxt;
      if (cfg_index == CFG_RES_COUNT)  nr_r <= nr_nxt;
    end
  end

  bsrc_ctrl #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .PW            (PW),
    .PCW           (PCW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .np      (np_r),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd),
    .idx     (idx)
  );

  bsrc_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .PW            (PW),
    .PCW           (PCW),
    .RCW           (RCW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .idx        (idx),
    .np         (np_r),
    .nr         (nr_r),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

### rtl/core/bsrc_datapath.sv
// tables, pools, lane compares and result register of the request checker
`timescale 1ns / 1ps

module bsrc_datapath
  import bsrc_pkg::*;
#(
  parameter int MAX_PROCESSES = 8,
  parameter int MAX_RESOURCES = 4,
  parameter int PW  = $clog2(MAX_PROCESSES),
  parameter int PCW = $clog2(MAX_PROCESSES + 1),
  parameter int RCW = $clog2(MAX_RESOURCES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  req_item_t       in_item,
  input  ctrl_cmd_t       cmd,
  input  logic [PW-1:0]   idx,
  input  logic [PCW-1:0]  np,
  input  logic [RCW-1:0]  nr,
  output dp_stat_t        stat,
  output logic            out_valid,
  output req_result_t     out_result
);

  typedef logic [MAX_RESOURCES-1:0][DATA_W-1:0] row_t;

  // table memories, one row of resources per process
  row_t alloc_mem [MAX_PROCESSES];
  row_t claim_mem [MAX_PROCESSES];

  row_t                          alloc_row_r;
  row_t                          claim_row_r;
  row_t                          prow_r;
  row_t                          avail_r;
  row_t                          pending_r;
  logic [MAX_RESOURCES-1:0][WORK_W-1:0] work_r;
  logic [MAX_PROCESSES-1:0]      finished_r;
  logic [PW-1:0]                 seq_r [MAX_PROCESSES];
  logic                          out_valid_r;
  req_result_t                   out_result_r;

  logic [PW-1:0]                 mem_addr;
  logic                          in_tables;
  logic [MAX_RESOURCES-1:0]      active;
  logic [MAX_RESOURCES-1:0]      alloc_we;
  logic [MAX_RESOURCES-1:0]      claim_we;
  row_t                          alloc_wd;
  logic [MAX_RESOURCES-1:0][NEED_W-1:0] need;
  logic [MAX_RESOURCES-1:0][WORK_W-1:0] work_sum;
  logic [PW-1:0]                 seq_head;

  // item writes use the item's process, everything else the controller's index
  assign mem_addr  = cmd.take ? PW'(in_item.process_index) : idx;
  assign in_tables = (int'(in_item.process_index) < MAX_PROCESSES) &&
                     (int'(in_item.resource_index) < MAX_RESOURCES);

  // per-lane need, work update and write enables
  always_comb begin
    logic [WORK_W:0] sum;
    for (int k = 0; k < MAX_RESOURCES; k++) begin
      active[k]   = k < int'(nr);
      need[k]     = {{(NEED_W-DATA_W){1'b0}}, claim_row_r[k]} -
                    {{(NEED_W-DATA_W){1'b0}}, alloc_row_r[k]};
      sum         = {1'b0, work_r[k]} + {{(WORK_W+1-DATA_W){1'b0}}, alloc_row_r[k]};
      work_sum[k] = (sum > {1'b0, WORK_MAX}) ? WORK_MAX : sum[WORK_W-1:0];
      alloc_we[k] = 1'b0;
      alloc_wd[k] = prow_r[k];
      claim_we[k] = cmd.take && (in_item.operation == OP_WR_CLAIM) && in_tables &&
                    (int'(in_item.resource_index) == k);
      if (cmd.take && (in_item.operation == OP_WR_ALLOC) && in_tables &&
          (int'(in_item.resource_index) == k)) begin
        alloc_we[k] = 1'b1;
        alloc_wd[k] = in_item.value;
      end else if (cmd.grant && active[k]) begin
        alloc_we[k] = 1'b1;
        alloc_wd[k] = alloc_row_r[k] + pending_r[k];
      end else if (cmd.rollback && active[k]) begin
        alloc_we[k] = 1'b1;
        alloc_wd[k] = prow_r[k];
      end
    end
  end

  // request and safety compares over the lanes in use
  always_comb begin
    stat = '0;
    stat.fits = 1'b1;
    for (int k = 0; k < MAX_RESOURCES; k++) begin
      if (active[k]) begin
        if ($signed({{(NEED_W-DATA_W){1'b0}}, pending_r[k]}) > $signed(need[k]))
          stat.over_need = 1'b1;
        if (pending_r[k] > avail_r[k])
          stat.over_avail = 1'b1;
        if ($signed(need[k]) > $signed({{(NEED_W-WORK_W){1'b0}}, work_r[k]}))
          stat.fits = 1'b0;
      end
    end
    stat.proc_done = finished_r[idx];
  end

  // table memories: lane writes, registered row read
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESOURCES; k++) begin
      if (alloc_we[k]) alloc_mem[mem_addr][k] <= alloc_wd[k];
      if (claim_we[k]) claim_mem[mem_addr][k] <= in_item.value;
    end
    if (cmd.rd_row) begin
      alloc_row_r <= alloc_mem[mem_addr];
      claim_row_r <= claim_mem[mem_addr];
    end
  end

  // available pool and saved allocation row of the requesting process
  always_ff @(posedge clk) begin
    if (cmd.grant) prow_r <= alloc_row_r;
    for (int k = 0; k < MAX_RESOURCES; k++) begin
      if (cmd.take && (in_item.operation == OP_WR_AVAIL) &&
          (int'(in_item.resource_index) == k)) begin
        avail_r[k] <= in_item.value;
      end else if (cmd.grant && active[k]) begin
        avail_r[k] <= avail_r[k] - pending_r[k];
      end else if (cmd.rollback && active[k]) begin
        avail_r[k] <= avail_r[k] + pending_r[k];
      end
    end
  end

  // pending request, work pool and finished flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      work_r     <= '0;
      finished_r <= '0;
    end else begin
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        if (cmd.clr_pending) begin
          pending_r[k] <= '0;
        end else if (cmd.take && (in_item.operation == OP_REQ_ELEM) &&
                     (int'(in_item.resource_index) == k)) begin
          pending_r[k] <= in_item.value;
        end
        if (cmd.grant) begin
          work_r[k] <= WORK_W'(avail_r[k] - pending_r[k]);
        end else if (cmd.commit && active[k]) begin
          work_r[k] <= work_sum[k];
        end
      end
      if (cmd.grant) begin
        finished_r <= '0;
      end else if (cmd.commit) begin
        finished_r[idx] <= 1'b1;
      end
    end
  end

  // safe sequence: committed processes shift in, head sits at np-1
  assign seq_head = seq_r[PW'(np - PCW'(1))];

  always_ff @(posedge clk) begin
    if (cmd.commit || (cmd.emit && cmd.emit_seq)) begin
      for (int k = 1; k < MAX_PROCESSES; k++) seq_r[k] <= seq_r[k-1];
      if (cmd.commit) seq_r[0] <= idx;
    end
  end

  // result register, each result shown for a single cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_result_r.status           <= cmd.emit_status;
      out_result_r.sequence_process <= cmd.emit_seq ? PIDX_W'(seq_head) : '0;
      out_result_r.last_result      <= cmd.emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // a result strobe always follows an emit command
  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.emit))
    else $error("result strobe without emit command");

  // a grant starts the check with no process finished
  a_grant_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.grant) |-> (finished_r == '0))
    else $error("finished flags not cleared by grant");

  // a process is only committed when its need fits the work pool
  a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (stat.fits && !stat.proc_done))
    else $error("commit of a process that does not fit");

endmodule

### rtl/core/bsrc_ctrl.sv
// controller state machine of the request checker
`timescale 1ns / 1ps

module bsrc_ctrl
  import bsrc_pkg::*;
#(
  parameter int MAX_PROCESSES = 8,
  parameter int PW  = $clog2(MAX_PROCESSES),
  parameter int PCW = $clog2(MAX_PROCESSES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  req_item_t       in_item,
  input  logic [PCW-1:0]  np,
  input  dp_stat_t        stat,
  output logic            busy,
  output ctrl_cmd_t       cmd,
  output logic [PW-1:0]   idx
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REQ_RD   = 3'd1;
  localparam logic [2:0] S_REQ_CHK  = 3'd2;
  localparam logic [2:0] S_SC_RD    = 3'd3;
  localparam logic [2:0] S_SC_CHK   = 3'd4;
  localparam logic [2:0] S_ROLLBACK = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0]        state_r,  state_nxt;
  logic [PIDX_W-1:0] req_p_r,  req_p_nxt;
  logic [PW-1:0]     i_r,      i_nxt;
  logic [PCW-1:0]    cnt_r,    cnt_nxt;
  logic              found_r,  found_nxt;
  logic              adv;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    req_p_nxt = req_p_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    adv       = 1'b0;
    cmd       = '0;
    idx       = i_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.take = 1'b1;
          if ((in_item.operation == OP_REQ_ELEM) && in_item.is_last) begin
            req_p_nxt = in_item.process_index;
            state_nxt = S_REQ_RD;
          end else begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = (in_item.operation == OP_REQ_ELEM) ? ST_STORED : ST_WRITTEN;
          end
        end
      end
      S_REQ_RD: begin
        idx = PW'(req_p_r);
        if (int'(req_p_r) >= int'(np)) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = ST_EXCEEDS;
          cmd.clr_pending = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_row = 1'b1;
          state_nxt  = S_REQ_CHK;
        end
      end
      S_REQ_CHK: begin
        idx = PW'(req_p_r);
        if (stat.over_need || stat.over_avail) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = stat.over_need ? ST_EXCEEDS : ST_UNAVAIL;
          cmd.clr_pending = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.grant = 1'b1;
          i_nxt     = '0;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (stat.proc_done) begin
          adv = 1'b1;
        end else begin
          cmd.rd_row = 1'b1;
          state_nxt  = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (stat.fits) begin
          cmd.commit = 1'b1;
          cnt_nxt    = cnt_r + PCW'(1);
          found_nxt  = 1'b1;
        end
        adv = 1'b1;
      end
      S_ROLLBACK: begin
        idx             = PW'(req_p_r);
        cmd.rollback    = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_last   = 1'b1;
        cmd.emit_status = ST_UNSAFE;
        cmd.clr_pending = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_EMIT: begin
        cmd.emit        = 1'b1;
        cmd.emit_seq    = 1'b1;
        cmd.emit_status = ST_SAFE;
        cmd.emit_last   = ((cnt_r + PCW'(1)) == np);
        cnt_nxt         = cnt_r + PCW'(1);
        if (cmd.emit_last) begin
          cmd.clr_pending = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // step to the next process, closing a pass at the last one
    if (adv) begin
      state_nxt = S_SC_RD;
      if (PCW'(i_r) == (np - PCW'(1))) begin
        i_nxt = '0;
        if (cnt_nxt == np) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end else if (!found_nxt) begin
          state_nxt = S_ROLLBACK;
        end else begin
          found_nxt = 1'b0;
        end
      end else begin
        i_nxt = i_r + PW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      req_p_r <= '0;
      i_r     <= '0;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      req_p_r <= req_p_nxt;
      i_r     <= i_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
    end
  end

  // the request check always works on a row read the cycle before
  a_req_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REQ_CHK) |-> ($past(state_r) == S_REQ_RD))
    else $error("request check without row read");

  // the fit check always works on a row read the cycle before
  a_sc_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_CHK) |-> ($past(state_r) == S_SC_RD && $past(cmd.rd_row)))
    else $error("fit check without row read");

  // sequence output never runs past the process count
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r < np))
    else $error("safe sequence index beyond process count");

endmodule

### tb/tb_bankers_safety_request_checker.sv
// self-checking testbench of the banker's safety request checker
`timescale 1ns / 1ps

module tb_bankers_safety_request_checker;
  import bsrc_pkg::*;

  localparam int NPROC   = 8;
  localparam int NRES    = 4;
  localparam int N_RAND  = 24;         // random requests per count setting
  localparam int N_PHASE = 5;

  // one row of the directed table
  typedef struct {
    req_item_t item;
    bit        pinned;
    status_t   status;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  req_item_t            in_item;
  logic                 out_valid;
  req_result_t          out_result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // typed status of a directed row, sampled along with its request
  logic    row_status_en;
  status_t row_status;

  // mirror of the block state
  logic [DATA_W-1:0] alloc_tbl  [NPROC*NRES];
  logic [DATA_W-1:0] claim_tbl  [NPROC*NRES];
  logic [DATA_W-1:0] avail_pool [NRES];
  logic [DATA_W-1:0] pend_req   [NRES];
  logic [CFG_W-1:0]  proc_reg;
  logic [2:0]        res_reg;
  logic [2:0]        safe_seq   [NPROC];

  req_result_t step_results     [$];
  req_result_t expected_results [$];
  dir_row_t    directed_rows    [$];
  int          fail_count;
  bit          burst;

  bankers_safety_request_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void note_failure(string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endfunction

  // counts as the block reads them
  function automatic int live_procs();
    if (proc_reg == 0) return 1;
    if (proc_reg > NPROC) return NPROC;
    return int'(proc_reg);
  endfunction

  function automatic int live_res();
    if (res_reg == 0) return 1;
    if (res_reg > NRES) return NRES;
    return int'(res_reg);
  endfunction

  // remaining need, negative when allocation is above the claim
  function automatic int need_of(int p, int r);
    return int'(claim_tbl[p*NRES+r]) - int'(alloc_tbl[p*NRES+r]);
  endfunction

  function automatic void add_result(status_t st, logic [2:0] seq, logic last);
    req_result_t res;
    res.status           = st;
    res.sequence_process = seq;
    res.last_result      = last;
    step_results.push_back(res);
  endfunction

  // repeated passes over unfinished processes; fills safe_seq, 1 if safe
  function automatic bit find_safe_order(int np, int nr);
    int         work [NRES];
    logic [7:0] done;
    int         cnt;
    bit         found;
    bit         fits;
    done = '0;
    cnt  = 0;
    for (int j = 0; j < nr; j++) work[j] = int'(avail_pool[j]);
    while (cnt < np) begin
      found = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++)
            if (need_of(i, j) > work[j]) fits = 1'b0;
          if (fits) begin
            for (int j = 0; j < nr; j++) begin
              work[j] += int'(alloc_tbl[i*NRES+j]);
              if (work[j] > int'(WORK_MAX)) work[j] = int'(WORK_MAX);
            end
            safe_seq[cnt] = 3'(i);
            cnt++;
            done[i] = 1'b1;
            found   = 1'b1;
          end
        end
      end
      if (!found) return 1'b0;
    end
    return 1'b1;
  endfunction

  // results of one request, state updated in place
  task automatic bankers_step(input req_item_t it);
    int      np;
    int      nr;
    int      p;
    status_t verdict;
    step_results.delete();
    case (it.operation)
      OP_WR_ALLOC: begin
        alloc_tbl[it.process_index*NRES+it.resource_index] = it.value;
        add_result(ST_WRITTEN, 3'd0, 1'b1);
      end
      OP_WR_CLAIM: begin
        claim_tbl[it.process_index*NRES+it.resource_index] = it.value;
        add_result(ST_WRITTEN, 3'd0, 1'b1);
      end
      OP_WR_AVAIL: begin
        avail_pool[it.resource_index] = it.value;
        add_result(ST_WRITTEN, 3'd0, 1'b1);
      end
      default: begin
        pend_req[it.resource_index] = it.value;
        if (!it.is_last) begin
          add_result(ST_STORED, 3'd0, 1'b1);
        end else begin
          np = live_procs();
          nr = live_res();
          p  = int'(it.process_index);
          // ST_SAFE here means no refusal so far
          verdict = ST_SAFE;
          if (p >= np) verdict = ST_EXCEEDS;
          for (int j = 0; j < nr; j++)
            if (verdict == ST_SAFE && int'(pend_req[j]) > need_of(p, j)) verdict = ST_EXCEEDS;
          for (int j = 0; j < nr; j++)
            if (verdict == ST_SAFE && pend_req[j] > avail_pool[j]) verdict = ST_UNAVAIL;
          if (verdict == ST_SAFE) begin
            // tentative grant
            for (int j = 0; j < nr; j++) begin
              avail_pool[j]       = avail_pool[j] - pend_req[j];
              alloc_tbl[p*NRES+j] = alloc_tbl[p*NRES+j] + pend_req[j];
            end
            if (!find_safe_order(np, nr)) begin
              for (int j = 0; j < nr; j++) begin
                avail_pool[j]       = avail_pool[j] + pend_req[j];
                alloc_tbl[p*NRES+j] = alloc_tbl[p*NRES+j] - pend_req[j];
              end
              verdict = ST_UNSAFE;
            end
          end
          if (verdict == ST_SAFE) begin
            for (int n = 0; n < np; n++) add_result(ST_SAFE, safe_seq[n], n == np - 1);
          end else begin
            add_result(verdict, 3'd0, 1'b1);
          end
          for (int j = 0; j < NRES; j++) pend_req[j] = '0;
        end
      end
    endcase
  endtask

  // prediction at acceptance, then result check
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_PROC_COUNT) proc_reg = cfg_data;
        else res_reg = cfg_data[2:0];
      end
      if (start && !busy) begin
        bankers_step(in_item);
        if (row_status_en) begin
          step_results.delete();
          add_result(row_status, 3'd0, 1'b1);
        end
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d seq %0d last %0d",
                                 out_result.status, out_result.sequence_process,
                                 out_result.last_result));
        end else begin
          if (out_result !== expected_results[0])
            note_failure($sformatf(
              "mismatch: expected status %0d seq %0d last %0d, got status %0d seq %0d last %0d",
              expected_results[0].status, expected_results[0].sequence_process,
              expected_results[0].last_result, out_result.status,
              out_result.sequence_process, out_result.last_result));
          void'(expected_results.pop_front());
        end
      end
    end
  end

  // one request with a random lead-in gap, returns at its acceptance edge
  task automatic send_request(input req_item_t it, input logic pinned, input status_t st);
    int gap;
    gap = burst ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_item       <= it;
    row_status_en <= pinned;
    row_status    <= st;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_counts(input logic [CFG_W-1:0] procs, input logic [CFG_W-1:0] ress);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROC_COUNT;
    cfg_data  <= procs;
    @(posedge clk);
    cfg_index <= CFG_RES_COUNT;
    cfg_data  <= ress;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(op_t op, int p, int r, int v, bit last,
                                      bit pinned, status_t st);
    dir_row_t d;
    d.item.operation      = op;
    d.item.process_index  = 3'(p);
    d.item.resource_index = 2'(r);
    d.item.value          = 8'(v);
    d.item.is_last        = last;
    d.pinned              = pinned;
    d.status              = st;
    return d;
  endfunction

  // mostly well-formed request sequences, some table writes, some noise
  task automatic run_random(input int n_items);
    int        sent;
    int        nel;
    int        np;
    int        kind;
    req_item_t it;
    sent = 0;
    np   = live_procs();
    while (sent < n_items) begin
      burst = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 9);
      if (kind < 3) begin
        it.operation      = op_t'($urandom_range(0, 2));
        it.process_index  = 3'($urandom_range(0, 7));
        it.resource_index = 2'($urandom_range(0, 3));
        it.is_last        = 1'($urandom_range(0, 1));
        case (it.operation)
          OP_WR_ALLOC: it.value = 8'($urandom_range(0, 4));
          OP_WR_CLAIM: it.value = 8'($urandom_range(2, 12));
          default:     it.value = 8'($urandom_range(0, 12));
        endcase
        if ($urandom_range(0, 7) == 0) it.value = 8'($urandom_range(0, 255));
        send_request(it, 1'b0, ST_WRITTEN);
        sent++;
      end else if (kind < 9) begin
        nel = $urandom_range(1, 4);
        for (int e = 0; e < nel; e++) begin
          it.operation      = OP_REQ_ELEM;
          it.resource_index = 2'($urandom_range(0, 3));
          it.value          = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 3));
          it.is_last        = (e == nel - 1);
          it.process_index  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                          : 3'($urandom_range(0, np - 1));
          send_request(it, 1'b0, ST_WRITTEN);
          sent++;
        end
      end else begin
        it = req_item_t'(16'($urandom));
        send_request(it, 1'b0, ST_WRITTEN);
        sent++;
      end
    end
    burst = 1'b0;
  endtask

  // main sequence
  initial begin
    req_item_t        it;
    logic [CFG_W-1:0] phase_procs [N_PHASE];
    logic [CFG_W-1:0] phase_res   [N_PHASE];
    phase_procs = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd8};
    phase_res   = '{4'd7, 4'd1, 4'd0, 4'd2, 4'd4};

    fail_count    = 0;
    burst         = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PROC_COUNT;
    cfg_data      = '0;
    row_status_en = 1'b0;
    row_status    = ST_WRITTEN;
    proc_reg      = CFG_W'(PROC_COUNT_RST);
    res_reg       = 3'(RES_COUNT_RST);
    for (int i = 0; i < NPROC*NRES; i++) begin
      alloc_tbl[i] = '0;
      claim_tbl[i] = '0;
    end
    for (int j = 0; j < NRES; j++) begin
      avail_pool[j] = '0;
      pend_req[j]   = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every entry: allocation 1, claim 6, pool 5
    for (int p = 0; p < NPROC; p++)
      for (int r = 0; r < NRES; r++) begin
        it = mk_row(OP_WR_ALLOC, p, r, 1, 1'b0, 1'b0, ST_WRITTEN).item;
        send_request(it, 1'b0, ST_WRITTEN);
        it = mk_row(OP_WR_CLAIM, p, r, 6, 1'b0, 1'b0, ST_WRITTEN).item;
        send_request(it, 1'b0, ST_WRITTEN);
      end
    for (int r = 0; r < NRES; r++) begin
      it = mk_row(OP_WR_AVAIL, 0, r, 5, 1'b0, 1'b0, ST_WRITTEN).item;
      send_request(it, 1'b0, ST_WRITTEN);
    end

    // directed table; unpinned rows are grants left to the predictor
    directed_rows.push_back(mk_row(OP_WR_ALLOC, 0, 0,   0, 1, 1, ST_WRITTEN)); // last ignored
    directed_rows.push_back(mk_row(OP_WR_CLAIM, 7, 3, 255, 0, 1, ST_WRITTEN));
    directed_rows.push_back(mk_row(OP_WR_AVAIL, 0, 3, 255, 0, 1, ST_WRITTEN));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 0, 0, 255, 0, 1, ST_STORED));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 0, 1,   0, 1, 1, ST_EXCEEDS)); // 255 > need
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 2, 2,   3, 0, 1, ST_STORED));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 2, 0,   2, 1, 0, ST_SAFE));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 1, 1,   6, 1, 1, ST_EXCEEDS)); // need is 5
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 3, 0,   4, 1, 1, ST_UNAVAIL)); // pool is 3
    // empty pool of resource 3: nobody can finish, grant rolled back
    directed_rows.push_back(mk_row(OP_WR_AVAIL, 0, 3,   0, 0, 1, ST_WRITTEN));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 4, 1,   1, 1, 1, ST_UNSAFE));
    // allocation above claim: negative need refuses even a zero request
    directed_rows.push_back(mk_row(OP_WR_ALLOC, 5, 1, 200, 0, 1, ST_WRITTEN));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 5, 1,   0, 1, 1, ST_EXCEEDS));
    directed_rows.push_back(mk_row(OP_WR_AVAIL, 0, 3, 255, 0, 1, ST_WRITTEN));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 6, 0,   1, 1, 0, ST_SAFE));
    directed_rows.push_back(mk_row(OP_REQ_ELEM, 0, 0,   0, 1, 0, ST_SAFE));    // zero request
    directed_rows.push_back(mk_row(OP_WR_CLAIM, 7, 3,   6, 0, 1, ST_WRITTEN));
    foreach (directed_rows[i])
      send_request(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].status);

    // random phases over several count settings, extremes included
    for (int ph = 0; ph < N_PHASE; ph++) begin
      start <= 1'b0;
      wait_drained();
      write_counts(phase_procs[ph], phase_res[ph]);
      run_random(N_RAND);
    end

    start <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bsrc_pkg.sv
rtl/core/bsrc_datapath.sv
rtl/core/bsrc_ctrl.sv
rtl/core/bankers_safety_request_checker.sv
tb/tb_bankers_safety_request_checker.sv
